FILE: hdl/esi_pkg.sv
package esi_pkg;

   localparam int DATA_W   = 48;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 10;
   localparam int TENSOR_N = 81;

   localparam logic [2:0] ACT_CLEAR  = 3'd0;
   localparam logic [2:0] ACT_TENSOR = 3'd1;
   localparam logic [2:0] ACT_GRAD   = 3'd2;
   localparam logic [2:0] ACT_INTEG  = 3'd3;
   localparam logic [2:0] ACT_READ   = 3'd4;

   localparam logic [1:0] REG_DIMENSION  = 2'd0;
   localparam logic [1:0] REG_NODE_COUNT = 2'd1;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_INTEG = 1'b1;

   typedef struct packed {
      logic [2:0]                action;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     kind;
      logic [INDEX_W-1:0]       entry_index;
      logic signed [DATA_W-1:0] entry_value;
      logic                     saturated;
   } rsp_type;

   // clip a 50-bit signed value to 48 bits
   function automatic logic [DATA_W:0] clip48(input logic signed [DATA_W+1:0] v);
      logic signed [DATA_W+1:0] pos_lim;
      logic signed [DATA_W+1:0] neg_lim;
      pos_lim = {3'b000, {(DATA_W-1){1'b1}}};
      neg_lim = ~pos_lim;
      if (v > pos_lim)      clip48 = {1'b1, pos_lim[DATA_W-1:0]};
      else if (v < neg_lim) clip48 = {1'b1, neg_lim[DATA_W-1:0]};
      else                  clip48 = {1'b0, v[DATA_W-1:0]};
   endfunction

endpackage

FILE: hdl/esi_ram.sv
module esi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/esi_mulq.sv
// Rounded Q product of a 48-bit and a 32-bit signed value, saturated to 48 bits.
// Two 24x32 partial products; registered as magnitudes, partial products, result.
module esi_mulq #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        start,
   input  logic signed [47:0] a,
   input  logic signed [31:0] b,
   output logic        done,
   output logic signed [47:0] y,
   output logic        clipped
);
   import esi_pkg::*;

   logic        neg_ff, neg2_ff, v1_ff, v2_ff, v3_ff;
   logic [47:0] ua_ff;
   logic [31:0] ub_ff;
   logic [55:0] plo_ff, phi_ff;
   logic [47:0] y_ff;
   logic        clip_ff;
   logic [48:0] pos_l, neg_l, lim, mag;
   logic [80:0] full;
   logic [80:0] rnd;

   always_ff @(posedge clock) begin
      v1_ff  <= start;
      neg_ff <= a[47] ^ b[31];
      ua_ff  <= a[47] ? 48'(-a) : 48'(a);
      ub_ff  <= b[31] ? 32'(-b) : 32'(b);
      v2_ff   <= v1_ff;
      neg2_ff <= neg_ff;
      plo_ff  <= 56'(ua_ff[23:0]) * 56'(ub_ff);
      phi_ff  <= 56'(ua_ff[47:24]) * 56'(ub_ff);
      v3_ff   <= v2_ff;
      y_ff    <= neg2_ff ? 48'(-mag) : 48'(mag);
      clip_ff <= (rnd[80:FRACTION_BITS] > 81'(lim));
   end

   always_comb begin
      pos_l = 49'h0_7FFF_FFFF_FFFF;
      neg_l = 49'h0_8000_0000_0000;
      lim   = neg2_ff ? neg_l : pos_l;
      full  = {phi_ff, 24'd0} + 81'(plo_ff);
      rnd   = full + (81'(1) << (FRACTION_BITS - 1));
      if (rnd[80:FRACTION_BITS] > 81'(lim)) mag = lim;
      else                                  mag = 49'(rnd[80:FRACTION_BITS]);
   end

   assign done    = v3_ff;
   assign y       = y_ff;
   assign clipped = clip_ff;
endmodule

FILE: hdl/esi_seq.sv
// Walks a,b,i,j,k,l for an integrate; one multiply in flight at a time.
module esi_seq #(
   parameter int MAX_NODES = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  dim,
   input  logic [4:0]  nodes,
   input  logic signed [31:0] weight,
   output logic        finish,
   output logic        flag,
   output logic [$clog2(esi_pkg::TENSOR_N)-1:0] t_addr,
   input  logic [31:0] t_data,
   output logic [$clog2(3 * MAX_NODES)-1:0] g_addr,
   input  logic [31:0] g_data,
   output logic [$clog2(9 * MAX_NODES * MAX_NODES)-1:0] s_rd_addr,
   input  logic [47:0] s_rd_data,
   output logic        s_wr_en,
   output logic [$clog2(9 * MAX_NODES * MAX_NODES)-1:0] s_wr_addr,
   output logic [47:0] s_wr_data
);
   import esi_pkg::*;
   localparam int GDEP = 3 * MAX_NODES;
   localparam int SDEP = GDEP * GDEP;
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int GW = $clog2(GDEP);
   localparam int SW = $clog2(SDEP);
   localparam int TW = $clog2(TENSOR_N);

   localparam logic [3:0] S_IDLE = 4'd0, S_RGA = 4'd1, S_RT = 4'd2, S_M1 = 4'd3,
      S_W1 = 4'd4, S_RGB = 4'd5, S_M2 = 4'd6, S_W2 = 4'd7, S_RS = 4'd8,
      S_M3 = 4'd9, S_W3 = 4'd10, S_DONE = 4'd11, S_WAIT = 4'd12;

   logic [3:0]  st_ff, st_in;
   logic [NW-1:0] a_ff, a_in, b_ff, b_in, n_ff, n_in;
   logic [1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in, l_ff, l_in, d_ff, d_in;
   logic signed [47:0] s_ff, s_in, kij_ff, kij_in;
   logic signed [31:0] ga_ff, ga_in, w_ff, w_in;
   logic        flag_ff, flag_in;
   logic        m_start;
   logic signed [47:0] m_a;
   logic signed [31:0] m_b;
   logic        m_done, m_clip;
   logic signed [47:0] m_y;
   logic [DATA_W:0] cl;
   logic [SW-1:0] pos;
   logic [GW-1:0] big;

   esi_mulq #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock(clock), .start(m_start), .a(m_a), .b(m_b),
      .done(m_done), .y(m_y), .clipped(m_clip));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         flag_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         flag_ff <= flag_in;
      end
      a_ff <= a_in; b_ff <= b_in; n_ff <= n_in; d_ff <= d_in;
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; l_ff <= l_in;
      s_ff <= s_in; kij_ff <= kij_in; ga_ff <= ga_in; w_ff <= w_in;
   end

   always_comb begin
      big = GW'(SW'(d_ff) * SW'(n_ff));
      pos = SW'(d_ff) * SW'(a_ff) + SW'(i_ff)
          + SW'(big) * (SW'(d_ff) * SW'(b_ff) + SW'(j_ff));
      t_addr = TW'(i_ff) + TW'(d_ff) * TW'(l_ff) + TW'(d_ff) * TW'(d_ff) * TW'(j_ff)
             + TW'(d_ff) * TW'(d_ff) * TW'(d_ff) * TW'(k_ff);
      g_addr = (st_ff == S_RGB) ? GW'(d_ff) * GW'(b_ff) + GW'(k_ff)
                                : GW'(d_ff) * GW'(a_ff) + GW'(l_ff);
      s_rd_addr = pos;
   end

   always_comb begin
      st_in = st_ff; flag_in = flag_ff & ~start;
      a_in = a_ff; b_in = b_ff; n_in = n_ff; d_in = d_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; l_in = l_ff;
      s_in = s_ff; kij_in = kij_ff; ga_in = ga_ff; w_in = w_ff;
      m_start = 1'b0; m_a = 48'(ga_ff); m_b = $signed(t_data);
      s_wr_en = 1'b0; s_wr_addr = pos; s_wr_data = 48'd0;
      finish = 1'b0; cl = '0;
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               flag_in = 1'b0;
               d_in = dim; w_in = weight;
               n_in = (nodes > 5'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(nodes);
               a_in = '0; b_in = '0; i_in = '0; j_in = '0; k_in = '0; l_in = '0;
               s_in = '0; kij_in = '0;
               if ((dim == 2'd2 || dim == 2'd3) && nodes != 5'd0) st_in = S_RGA;
               else st_in = S_DONE;
            end
         end
         S_RGA: st_in = S_RT;
         S_RT: begin
            ga_in = $signed(g_data);
            st_in = S_M1;
         end
         S_M1: begin
            m_start = 1'b1; m_a = 48'(ga_ff); m_b = $signed(t_data);
            st_in = S_W1;
         end
         S_W1: if (m_done) begin
            cl = clip48(50'(s_ff) + 50'(m_y));
            if (cl[DATA_W] || m_clip) flag_in = 1'b1;
            s_in = $signed(cl[DATA_W-1:0]);
            if (l_ff == d_ff - 2'd1) begin
               l_in = '0; st_in = S_RGB;
            end else begin
               l_in = l_ff + 2'd1; st_in = S_RGA;
            end
         end
         S_RGB: st_in = S_M2;
         S_M2: begin
            m_start = 1'b1; m_a = s_ff; m_b = $signed(g_data);
            st_in = S_W2;
         end
         S_W2: if (m_done) begin
            cl = clip48(50'(kij_ff) + 50'(m_y));
            if (cl[DATA_W] || m_clip) flag_in = 1'b1;
            kij_in = $signed(cl[DATA_W-1:0]);
            s_in = '0;
            if (k_ff == d_ff - 2'd1) begin
               k_in = '0; st_in = S_RS;
            end else begin
               k_in = k_ff + 2'd1; st_in = S_RGA;
            end
         end
         S_RS: st_in = S_M3;
         S_M3: begin
            m_start = 1'b1; m_a = kij_ff; m_b = w_ff;
            st_in = S_W3;
         end
         S_W3: if (m_done) begin
            cl = clip48(50'($signed(s_rd_data)) + 50'(m_y));
            if (cl[DATA_W] || m_clip) flag_in = 1'b1;
            s_wr_en = 1'b1; s_wr_data = cl[DATA_W-1:0];
            kij_in = '0;
            st_in = S_WAIT;
            if (j_ff != d_ff - 2'd1) j_in = j_ff + 2'd1;
            else begin
               j_in = '0;
               if (i_ff != d_ff - 2'd1) i_in = i_ff + 2'd1;
               else begin
                  i_in = '0;
                  if (b_ff != n_ff - 1'b1) b_in = b_ff + 1'b1;
                  else begin
                     b_in = '0;
                     if (a_ff != n_ff - 1'b1) a_in = a_ff + 1'b1;
                     else st_in = S_DONE;
                  end
               end
            end
         end
         S_WAIT: st_in = S_RGA;
         S_DONE: begin
            finish = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign flag = flag_ff;
endmodule

FILE: hdl/element_stiffness_integrator_core.sv
// Stiffness integrator. Load items are written straight into their RAM; a read
// does one RAM read, then registers the result word. An integrate item is paced
// by a single shared multiplier walking every term in turn. A clear sweeps the
// 48-bit matrix RAM, all (3*MAX_NODES)^2 words; the same sweep runs after reset,
// and no word is taken until it finishes. One item in flight at a time.
module element_stiffness_integrator_core #(
   parameter int MAX_NODES = 8,
   parameter int FRACTION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  esi_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output esi_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_data
);
   import esi_pkg::*;
   localparam int GDEP = 3 * MAX_NODES;
   localparam int SDEP = GDEP * GDEP;
   localparam int SW = $clog2(SDEP);
   localparam int GW = $clog2(GDEP);

   localparam logic [2:0] P_IDLE = 3'd0, P_CLR = 3'd1, P_RD = 3'd2,
      P_INT = 3'd3, P_OUT = 3'd4;

   logic [2:0]  ph_ff, ph_in;
   logic [1:0]  dim_ff;
   logic [3:0]  nodes_ff;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic        ovf_ff, ovf_in;
   logic        rv_ff, rv_in;
   rsp_type     rsp_ff, rsp_in;
   logic [INDEX_W-1:0] ridx_ff, ridx_in;
   logic        take;

   logic [6:0]  t_addr;
   logic [31:0] t_data, g_data;
   logic [GW-1:0] g_addr;
   logic [SW-1:0] sq_rd, sq_wa, s_rd, s_wa;
   logic [47:0] s_rd_data, sq_wd, s_wd;
   logic        sq_we, s_we, sq_fin, sq_flag;

   assign take = req_valid && !req_stall;
   assign req_stall = (ph_ff != P_IDLE) || rv_ff;

   esi_ram #(.WIDTH(32), .DEPTH(TENSOR_N)) u_tensor (
      .clock(clock),
      .wr_en(take && req_data.action == ACT_TENSOR && req_data.index < 10'(TENSOR_N)),
      .wr_addr(req_data.index[6:0]), .wr_data(req_data.value),
      .rd_addr(t_addr), .rd_data(t_data));

   esi_ram #(.WIDTH(32), .DEPTH(GDEP)) u_grad (
      .clock(clock),
      .wr_en(take && req_data.action == ACT_GRAD && req_data.index < 10'(GDEP)),
      .wr_addr(GW'(req_data.index)), .wr_data(req_data.value),
      .rd_addr(g_addr), .rd_data(g_data));

   esi_ram #(.WIDTH(48), .DEPTH(SDEP)) u_stiff (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_rd), .rd_data(s_rd_data));

   esi_seq #(.MAX_NODES(MAX_NODES), .FRACTION_BITS(FRACTION_BITS)) u_seq (
      .clock(clock), .reset(reset),
      .start(take && req_data.action == ACT_INTEG),
      .dim(dim_ff), .nodes({1'b0, nodes_ff}), .weight(req_data.value),
      .finish(sq_fin), .flag(sq_flag),
      .t_addr(t_addr), .t_data(t_data), .g_addr(g_addr), .g_data(g_data),
      .s_rd_addr(sq_rd), .s_rd_data(s_rd_data),
      .s_wr_en(sq_we), .s_wr_addr(sq_wa), .s_wr_data(sq_wd));

   always_comb begin
      s_rd = (ph_ff == P_INT) ? sq_rd : SW'(req_data.index);
      s_we = sq_we; s_wa = sq_wa; s_wd = sq_wd;
      if (ph_ff == P_CLR) begin
         s_we = 1'b1; s_wa = cnt_ff; s_wd = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= P_CLR; cnt_ff <= '0; ovf_ff <= 1'b0; rv_ff <= 1'b0;
         dim_ff <= 2'd3; nodes_ff <= 4'd8;
      end else begin
         ph_ff <= ph_in; cnt_ff <= cnt_in; ovf_ff <= ovf_in; rv_ff <= rv_in;
         if (csr_write && csr_index == REG_DIMENSION) dim_ff <= csr_data[1:0];
         if (csr_write && csr_index == REG_NODE_COUNT) nodes_ff <= csr_data;
      end
      rsp_ff <= rsp_in; ridx_ff <= ridx_in;
   end

   always_comb begin
      ph_in = ph_ff; cnt_in = cnt_ff; ovf_in = ovf_ff; rv_in = rv_ff;
      rsp_in = rsp_ff; ridx_in = ridx_ff;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      case (ph_ff)
         P_IDLE: if (take) begin
            ridx_in = req_data.index;
            case (req_data.action)
               ACT_CLEAR: begin
                  ph_in = P_CLR; cnt_in = '0; ovf_in = 1'b0;
               end
               ACT_INTEG: ph_in = P_INT;
               ACT_READ:  ph_in = P_RD;
               default:   ph_in = P_IDLE;
            endcase
         end
         P_CLR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SW'(SDEP - 1)) ph_in = P_IDLE;
         end
         P_RD: begin
            rsp_in.kind = KIND_READ;
            rsp_in.entry_index = ridx_ff;
            rsp_in.entry_value = (ridx_ff < 10'(SDEP)) ? $signed(s_rd_data) : '0;
            rsp_in.saturated = ovf_ff;
            rv_in = 1'b1; ph_in = P_IDLE;
         end
         P_INT: if (sq_fin) begin
            ovf_in = ovf_ff | sq_flag;
            rsp_in.kind = KIND_INTEG;
            rsp_in.entry_index = '0;
            rsp_in.entry_value = '0;
            rsp_in.saturated = ovf_ff | sq_flag;
            rv_in = 1'b1; ph_in = P_IDLE;
         end
         default: ph_in = P_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
endmodule

FILE: tb/esi_checker.sv
module esi_checker (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  esi_pkg::req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  esi_pkg::rsp_type rsp_data,
   input  logic    csr_write,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data,
   output int      errors,
   output int      pending
);
   import esi_pkg::*;

   localparam int FRAC = 16;
   localparam int NODES_MAX = 8;
   localparam int GRAD_N = 3 * NODES_MAX;
   localparam int STORE_N = GRAD_N * GRAD_N;
   localparam longint POS_LIM = 64'sh7FFF_FFFF_FFFF;
   localparam longint NEG_LIM = -64'sh8000_0000_0000;

   longint  stiffness [STORE_N];
   longint  tensor [TENSOR_N];
   longint  gradient [GRAD_N];
   bit      sat_seen;
   int      dim_reg;
   int      nodes_reg;
   rsp_type answers [$];

   function automatic longint clip(longint v);
      if (v > POS_LIM) begin
         sat_seen = 1;
         return POS_LIM;
      end
      if (v < NEG_LIM) begin
         sat_seen = 1;
         return NEG_LIM;
      end
      return v;
   endfunction

   // exact product, round half away from zero, clip magnitude
   function automatic longint mul_round(longint a, longint b);
      logic [95:0] p;
      logic [95:0] lim;
      bit          neg;
      neg = (a < 0) != (b < 0);
      p = 96'(a < 0 ? -a : a) * 96'(b < 0 ? -b : b);
      p = (p + (96'd1 << (FRAC - 1))) >> FRAC;
      lim = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
      if (p > lim) begin
         sat_seen = 1;
         p = lim;
      end
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic void integrate_point(longint w);
      int d;
      int n;
      int span;
      longint s;
      longint kij;
      int pos;
      if (dim_reg != 2 && dim_reg != 3) return;
      d = dim_reg;
      n = nodes_reg > NODES_MAX ? NODES_MAX : nodes_reg;
      span = d * n;
      for (int a = 0; a < n; a++)
         for (int b = 0; b < n; b++)
            for (int i = 0; i < d; i++)
               for (int j = 0; j < d; j++) begin
                  kij = 0;
                  for (int k = 0; k < d; k++) begin
                     s = 0;
                     for (int l = 0; l < d; l++)
                        s = clip(s + mul_round(gradient[d*a+l],
                                               tensor[i + d*l + d*d*j + d*d*d*k]));
                     kij = clip(kij + mul_round(s, gradient[d*b+k]));
                  end
                  pos = (d*a + i) + span * (d*b + j);
                  stiffness[pos] = clip(stiffness[pos] + mul_round(kij, w));
               end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         foreach (stiffness[e]) stiffness[e] = 0;
         foreach (tensor[e]) tensor[e] = 0;
         foreach (gradient[e]) gradient[e] = 0;
         sat_seen = 0;
         dim_reg = 3;
         nodes_reg = 8;
         answers.delete();
         errors <= 0;
      end else begin
         if (csr_write) begin
            if (csr_index == REG_DIMENSION) dim_reg = csr_data & 4'd3;
            else if (csr_index == REG_NODE_COUNT) nodes_reg = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (answers.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %p", $time, got);
               errors <= errors + 1;
            end else begin
               want = answers.pop_front();
               if (got.kind !== want.kind || got.entry_index !== want.entry_index ||
                   got.entry_value !== want.entry_value ||
                   got.saturated !== want.saturated) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_data.action)
               ACT_CLEAR: begin
                  foreach (stiffness[e]) stiffness[e] = 0;
                  sat_seen = 0;
               end
               ACT_TENSOR:
                  if (req_data.index < TENSOR_N) tensor[req_data.index] = req_data.value;
               ACT_GRAD:
                  if (req_data.index < GRAD_N) gradient[req_data.index] = req_data.value;
               ACT_INTEG: begin
                  integrate_point(longint'(req_data.value));
                  want.kind = KIND_INTEG;
                  want.entry_index = '0;
                  want.entry_value = '0;
                  want.saturated = sat_seen;
                  answers.push_back(want);
               end
               ACT_READ: begin
                  want.kind = KIND_READ;
                  want.entry_index = req_data.index;
                  want.entry_value = req_data.index < STORE_N ?
                                     stiffness[req_data.index][47:0] : '0;
                  want.saturated = sat_seen;
                  answers.push_back(want);
               end
               default: ;
            endcase
         end
      end
      pending <= answers.size();
   end

endmodule

FILE: tb/tb.sv
module tb;
   import esi_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [3:0] csr_data;
   int         errors;
   int         pending;
   bit         idle_on;
   int         n_words;
   int         n_integ;
   int         n_reads;
   int         n_settings;

   element_stiffness_integrator_core dut (.*);

   esi_checker chk (.*);

   initial clock = 0;
   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock)
      rsp_stall <= idle_on && $urandom_range(99) < 20;

   initial begin
      #(20 * 3000000);
      $display("== FAIL ==");
      $finish;
   end

   task automatic send(logic [2:0] act, int idx, logic [31:0] val);
      if (idle_on && $urandom_range(99) < 20) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_data <= '{action: act, index: idx[9:0], value: val};
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      n_words++;
      if (act == ACT_INTEG) n_integ++;
      if (act == ACT_READ) n_reads++;
   endtask

   // idle the channel, let results drain, allow for a clear sweep still running
   task automatic settle();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (700) @(posedge clock);
   endtask

   task automatic set_regs(int d, int n);
      settle();
      csr_write <= 1;
      csr_index <= REG_DIMENSION;
      csr_data <= 4'(d);
      @(posedge clock);
      csr_index <= REG_NODE_COUNT;
      csr_data <= 4'(n);
      @(posedge clock);
      csr_write <= 0;
      n_settings++;
   endtask

   function automatic logic [31:0] modest();
      return $urandom_range(99) < 75 ? 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18)
                                     : 32'($urandom);
   endfunction

   task automatic random_word(int d, int n);
      int r;
      int span;
      r = $urandom_range(99);
      span = (d == 2 || d == 3) ? d * (n > 8 ? 8 : n) : 1;
      if (r < 30)
         send(ACT_TENSOR, $urandom_range(99) < 90 ? $urandom_range(80) : $urandom_range(1023),
              modest());
      else if (r < 50)
         send(ACT_GRAD, $urandom_range(99) < 90 ? $urandom_range(23) : $urandom_range(1023),
              modest());
      else if (r < 64)
         send(ACT_INTEG, 0, modest());
      else if (r < 88)
         send(ACT_READ, $urandom_range(99) < 60 ? $urandom_range(span * span - 1)
                                                : $urandom_range(1023), $urandom);
      else if (r < 93)
         send(ACT_CLEAR, $urandom_range(1023), $urandom);
      else
         send(3'($urandom_range(5, 7)), $urandom_range(1023), $urandom);
   endtask

   initial begin
      int dims [8] = '{2, 3, 2, 3, 0, 1, 2, 3};
      int nodes [8] = '{1, 1, 2, 2, 1, 3, 0, 3};
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      idle_on = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // load every tensor and gradient entry so no integrate reads an unset one
      for (int e = 0; e < TENSOR_N; e++) send(ACT_TENSOR, e, modest());
      for (int e = 0; e < 24; e++) send(ACT_GRAD, e, modest());

      send(ACT_TENSOR, 81, 32'h7FFF_FFFF);
      send(ACT_TENSOR, 1023, 32'h8000_0000);
      send(ACT_GRAD, 24, 32'h7FFF_FFFF);
      send(ACT_GRAD, 1023, 32'hFFFF_FFFF);
      send(ACT_READ, 0, 0);
      send(ACT_READ, 575, 0);
      send(ACT_READ, 576, 0);
      send(ACT_READ, 1023, 0);
      send(ACT_INTEG, 0, 32'h0001_0000);
      send(ACT_READ, 0, 0);
      send(ACT_READ, 575, 0);
      send(ACT_GRAD, 0, 32'h8000_0000);
      send(ACT_GRAD, 1, 32'h7FFF_FFFF);
      send(ACT_INTEG, 0, 32'h7FFF_FFFF);
      send(ACT_INTEG, 0, 32'h8000_0000);
      send(ACT_READ, 1, 0);
      send(ACT_CLEAR, 0, 0);
      send(ACT_READ, 1, 0);
      send(3'd5, 3, 1);
      send(3'd6, 0, 0);
      send(3'd7, 1023, 32'hFFFF_FFFF);

      // node count above the maximum is clamped
      set_regs(3, 15);
      send(ACT_INTEG, 0, 32'h0000_8000);
      send(ACT_READ, 575, 0);

      for (int p = 0; p < 8; p++) begin
         set_regs(dims[p], nodes[p]);
         if (p == 3) idle_on = 0;
         for (int t = 0; t < 100; t++) random_word(dims[p], nodes[p]);
         idle_on = 1;
      end

      settle();
      $display("sent %0d words (%0d integrates, %0d reads) across %0d register settings",
               n_words, n_integ, n_reads, n_settings + 1);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/esi_pkg.sv
hdl/esi_ram.sv
hdl/esi_mulq.sv
hdl/esi_seq.sv
hdl/element_stiffness_integrator_core.sv
tb/esi_checker.sv
tb/tb.sv
